// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WSPF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("concurrent assertion failed");

// Next-cycle implication.
`define WSPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("concurrent assertion failed");

`endif

// File: hdl/wspf_pkg.sv
// ----------------------------------------------------------------------------
// wspf_pkg
// Widths, constants, register indexes and handshake structs of the wheel
// speed controller.
// ----------------------------------------------------------------------------
package wspf_pkg;

  localparam int FIELD_W     = 24;
  localparam int GAIN_W      = 16;
  localparam int LIMIT_W     = 23;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 23;

  // Serial multiplier: signed multiplicand, unsigned multiplier.
  localparam int MUL_A_W     = 25;
  localparam int MUL_B_W     = 16;
  localparam int PROD_W      = MUL_A_W + MUL_B_W + 1;
  localparam int SUM_W       = 44;

  // Serial divider by a small constant.
  localparam int DIV_NUM_W   = 32;
  localparam int DIV_DEN_W   = 7;

  localparam int DERIV_W     = 12;
  localparam int DERIV_MAG_W = DERIV_W - 1;
  localparam int OUT_SHIFT   = 8;

  localparam logic signed [FIELD_W-1:0] SMALL_TARGET_MAX = 24'sd25;
  localparam logic [DIV_DEN_W-1:0] INT_DIVISOR   = 7'd100;
  localparam logic [DIV_DEN_W-1:0] DERIV_DIVISOR = 7'd10;
  localparam logic [7:0] INT_HALF   = 8'd50;
  localparam logic [7:0] DERIV_HALF = 8'd5;
  localparam logic [7:0] OUT_HALF   = 8'd128;
  localparam logic [MUL_B_W-1:0] DECAY_COEF = 16'd9;
  localparam logic [MUL_B_W-1:0] DIFF_SCALE = 16'd100;
  localparam logic [MUL_B_W-1:0] DZ_SCALE   = 16'd256;
  localparam logic [DERIV_MAG_W-1:0] DERIV_LIMIT = 11'd1280;

  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST    = 23'd23040;
  localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 23'd76800;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P          = 3'd0,
    REG_GAIN_I          = 3'd1,
    REG_GAIN_D          = 3'd2,
    REG_DRIVE_LIMIT     = 3'd3,
    REG_INTEGRAL_LIMIT  = 3'd4,
    REG_DEADZONE_OFFSET = 3'd5,
    REG_FF_SLOPE        = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic [MUL_B_W-1:0] mult;
  } mul_req_t;

endpackage

// File: hdl/wspf_div.sv
// ----------------------------------------------------------------------------
// wspf_div
// Restoring divider of an unsigned numerator by a small divisor, one
// quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module wspf_div #(
  parameter int NUM_W = wspf_pkg::DIV_NUM_W
) (
  input  logic                clk,
  input  logic                rst,
  input  wspf_pkg::div_req_t  req,
  input  logic [NUM_W-1:0]    num,
  output logic                done,
  output logic [NUM_W-1:0]    quot
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
  localparam int DW    = wspf_pkg::DIV_DEN_W;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    den;
  logic [DW-1:0]    rem;
  logic [NUM_W-1:0] shreg;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fits;

  // The partial remainder stays below the divisor, so the trial value
  // needs only one bit more than the divisor.
  assign trial = {rem, shreg[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});
  assign diff  = trial - {1'b0, den};
  assign quot  = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den   <= req.den;
      rem   <= '0;
      shreg <= num;
    end else if (busy) begin
      rem   <= fits ? diff[DW-1:0] : trial[DW-1:0];
      shreg <= {shreg[NUM_W-2:0], fits};
    end
  end

endmodule

// File: hdl/wspf_mul.sv
// ----------------------------------------------------------------------------
// wspf_mul
// Shift-add multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module wspf_mul #(
  parameter int A_W = wspf_pkg::MUL_A_W
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  wspf_pkg::mul_req_t                       req,
  input  logic signed [A_W-1:0]                    a,
  output logic                                     done,
  output logic signed [A_W+wspf_pkg::MUL_B_W:0]    prod
);

  localparam int BW    = wspf_pkg::MUL_B_W;
  localparam int CNT_W = (BW > 1) ? $clog2(BW) : 1;

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic signed [A_W-1:0]   mcand;
  logic signed [A_W:0]     hi;
  logic signed [A_W:0]     hsum;
  logic [BW-1:0]           lo;

  // The upper half gains the multiplicand when the current multiplier bit
  // is set, then the whole product shifts right arithmetically.
  assign hsum = lo[0] ? (hi + {mcand[A_W-1], mcand}) : hi;
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= req.mult;
    end else if (busy) begin
      hi <= {hsum[A_W], hsum[A_W:1]};
      lo <= {hsum[0], lo[BW-1:1]};
    end
  end

endmodule

// File: hdl/wheel_speed_pid_feedforward_top.sv
// ----------------------------------------------------------------------------
// wheel_speed_pid_feedforward_top
// Wheel speed PID controller with feedforward, fixed point.
// ----------------------------------------------------------------------------
// Each input word carries a target and a measured speed (signed Q15.8) and
// produces one drive word (signed Q15.8), clamped to plus or minus the drive
// limit. The block works on one word at a time: a new word is taken only
// when the previous one has left the datapath, but a finished drive word
// waits in an output register, so the next word can enter while it is still
// unclaimed. The time from one accepted word to the earliest next accept
// is shorter when the target is small (magnitude 25 raw or less) than
// when it is large, provided the drive register is free when the result
// is ready. The time is set by the two shared serial units: the divider
// yields one quotient bit a cycle (in each of the two divisions, by 100
// and by 10), and the multiplier consumes one multiplier bit a cycle
// (five products for a small target and seven for a large one).
// Configuration registers may be written at any time the block is idle;
// writes to index 7 are ignored.
module wheel_speed_pid_feedforward_top (
  input  logic                               clk,
  input  logic                               rst,
  // Input words.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [2*wspf_pkg::FIELD_W-1:0]     s_axis_tdata,  // target, measured
  // Drive words.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [wspf_pkg::FIELD_W-1:0]       m_axis_tdata,  // drive
  // Register writes.
  input  logic                               cfg_wr_en,
  input  logic [wspf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wspf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int FW     = wspf_pkg::FIELD_W;
  localparam int GW     = wspf_pkg::GAIN_W;
  localparam int LW     = wspf_pkg::LIMIT_W;
  localparam int AW     = wspf_pkg::MUL_A_W;
  localparam int PW     = wspf_pkg::PROD_W;
  localparam int SW     = wspf_pkg::SUM_W;
  localparam int NW     = wspf_pkg::DIV_NUM_W;
  localparam int DRW    = wspf_pkg::DERIV_W;
  localparam int DMW    = wspf_pkg::DERIV_MAG_W;
  localparam int OMW    = SW - wspf_pkg::OUT_SHIFT;

  // Sequencer states.
  typedef enum logic [11:0] {
    ST_IDLE   = 12'h001,
    ST_ERR    = 12'h002,
    ST_IPREP  = 12'h004,
    ST_IDIV   = 12'h008,
    ST_IACC   = 12'h010,
    ST_MLOAD  = 12'h020,
    ST_MUL    = 12'h040,
    ST_DPREP  = 12'h080,
    ST_DDIV   = 12'h100,
    ST_DCLAMP = 12'h200,
    ST_RND    = 12'h400,
    ST_OUT    = 12'h800
  } state_t;

  // Which product the multiplier is working on.
  typedef enum logic [2:0] {
    T_DECAY = 3'd0,
    T_DIFF  = 3'd1,
    T_P     = 3'd2,
    T_I     = 3'd3,
    T_D     = 3'd4,
    T_FF    = 3'd5,
    T_DZ    = 3'd6
  } term_t;

  // Configuration registers.
  logic [GW-1:0] gain_p;
  logic [GW-1:0] gain_i;
  logic [GW-1:0] gain_d;
  logic [LW-1:0] drive_limit;
  logic [LW-1:0] integral_limit;
  logic [GW-1:0] deadzone_offset;
  logic [GW-1:0] ff_slope;

  // Control and loop state.
  state_t                 state;
  term_t                  term;
  logic                   out_valid;
  logic signed [FW-1:0]   integ;
  logic signed [FW-1:0]   prev_err;
  logic signed [DRW-1:0]  deriv;

  // Per-word working registers.
  logic signed [FW-1:0]   target;
  logic signed [FW-1:0]   measured;
  logic signed [FW-1:0]   err;
  logic                   big_target;
  logic                   sign_neg;
  logic signed [SW-1:0]   sum;
  logic [SW-1:0]          omag;
  logic [FW-1:0]          out_data;

  // Combinational datapath.
  logic signed [FW:0]     raw_diff;
  logic signed [FW-1:0]   err_sat;
  logic                   big_now;
  logic signed [SW-1:0]   rnd_src;
  logic [7:0]             rnd_half;
  logic                   rnd_neg;
  logic [SW-1:0]          rnd_mag;
  logic signed [FW:0]     iq;
  logic signed [FW:0]     isum;
  logic signed [FW:0]     ilim;
  logic signed [FW-1:0]   integ_new;
  logic [DMW-1:0]         dmag;
  logic signed [DRW-1:0]  deriv_new;
  logic [OMW-1:0]         omag_q;
  logic [LW-1:0]          cmag;
  logic [FW-1:0]          drive;
  logic                   out_load;
  logic signed [AW-1:0]   dz_ext;

  // Serial unit hookup.
  wspf_pkg::div_req_t     div_req;
  logic [NW-1:0]          div_num;
  logic                   div_done;
  logic [NW-1:0]          div_quot;
  wspf_pkg::mul_req_t     mul_req;
  logic signed [AW-1:0]   mul_a;
  logic                   mul_done;
  logic signed [PW-1:0]   prod;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Error is target minus measured, saturated to the field width.
  assign raw_diff = {target[FW-1], target} - {measured[FW-1], measured};
  always_comb begin
    if (raw_diff[FW] != raw_diff[FW-1]) begin
      err_sat = raw_diff[FW] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
    end else begin
      err_sat = raw_diff[FW-1:0];
    end
  end

  // Feedforward and the integral both hinge on this threshold.
  assign big_now = (target > wspf_pkg::SMALL_TARGET_MAX) ||
                   (target < -wspf_pkg::SMALL_TARGET_MAX);

  // One shared adder forms magnitude plus half the divisor, which turns the
  // floor division of a magnitude into round-half-away-from-zero.
  always_comb begin
    if (state == ST_IPREP) begin
      rnd_src  = {{(SW-FW){err[FW-1]}}, err};
      rnd_half = wspf_pkg::INT_HALF;
    end else if (state == ST_DPREP) begin
      rnd_src  = sum;
      rnd_half = wspf_pkg::DERIV_HALF;
    end else begin
      rnd_src  = sum;
      rnd_half = wspf_pkg::OUT_HALF;
    end
  end
  assign rnd_neg = rnd_src[SW-1];
  assign rnd_mag = (rnd_neg ? ~rnd_src : rnd_src) +
                   {{(SW-8){1'b0}}, rnd_neg ? (rnd_half + 8'd1) : rnd_half};

  assign div_req.start = (state == ST_IPREP) || (state == ST_DPREP);
  assign div_req.den   = (state == ST_IPREP) ? wspf_pkg::INT_DIVISOR
                                             : wspf_pkg::DERIV_DIVISOR;
  assign div_num       = rnd_mag[NW-1:0];

  wspf_div #(
    .NUM_W (NW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .num  (div_num),
    .done (div_done),
    .quot (div_quot)
  );

  // Operand selection for each product of the derivative filter and the
  // output sum.
  assign dz_ext = {{(AW-GW){1'b0}}, deadzone_offset};
  always_comb begin
    mul_req.start = (state == ST_MLOAD);
    case (term)
      T_DECAY: begin
        mul_a        = {{(AW-DRW){deriv[DRW-1]}}, deriv};
        mul_req.mult = wspf_pkg::DECAY_COEF;
      end
      T_DIFF: begin
        mul_a        = {err[FW-1], err} - {prev_err[FW-1], prev_err};
        mul_req.mult = wspf_pkg::DIFF_SCALE;
      end
      T_P: begin
        mul_a        = {{(AW-FW){err[FW-1]}}, err};
        mul_req.mult = gain_p;
      end
      T_I: begin
        mul_a        = {{(AW-FW){integ[FW-1]}}, integ};
        mul_req.mult = gain_i;
      end
      T_D: begin
        mul_a        = {{(AW-DRW){deriv[DRW-1]}}, deriv};
        mul_req.mult = gain_d;
      end
      T_FF: begin
        mul_a        = {{(AW-FW){target[FW-1]}}, target};
        mul_req.mult = ff_slope;
      end
      T_DZ: begin
        mul_a        = target[FW-1] ? -dz_ext : dz_ext;
        mul_req.mult = wspf_pkg::DZ_SCALE;
      end
      default: begin
        mul_a        = '0;
        mul_req.mult = '0;
      end
    endcase
  end

  wspf_mul #(
    .A_W (AW)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .a    (mul_a),
    .done (mul_done),
    .prod (prod)
  );

  // Integral update: add the signed quotient, then clamp symmetrically.
  assign iq   = {1'b0, div_quot[FW-1:0]};
  assign isum = {integ[FW-1], integ} + (sign_neg ? -iq : iq);
  assign ilim = {2'b00, integral_limit};
  always_comb begin
    if (isum > ilim) begin
      integ_new = ilim[FW-1:0];
    end else if (isum < -ilim) begin
      integ_new = FW'(-ilim);
    end else begin
      integ_new = isum[FW-1:0];
    end
  end

  // Filtered derivative: clamp the quotient magnitude, then restore sign.
  assign dmag      = (div_quot > {{(NW-DMW){1'b0}}, wspf_pkg::DERIV_LIMIT})
                     ? wspf_pkg::DERIV_LIMIT : div_quot[DMW-1:0];
  assign deriv_new = sign_neg ? -{1'b0, dmag} : {1'b0, dmag};

  // Drive: rounded magnitude shifted to Q.8, clamped, then signed.
  assign omag_q = omag[SW-1:wspf_pkg::OUT_SHIFT];
  assign cmag   = (omag_q > {{(OMW-LW){1'b0}}, drive_limit})
                  ? drive_limit : omag_q[LW-1:0];
  assign drive  = sign_neg ? -{1'b0, cmag} : {1'b0, cmag};

  assign out_load = (state == ST_OUT) && (!out_valid || m_axis_tready);

  // Control, configuration and loop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      term            <= T_DECAY;
      out_valid       <= 1'b0;
      integ           <= '0;
      prev_err        <= '0;
      deriv           <= '0;
      gain_p          <= '0;
      gain_i          <= '0;
      gain_d          <= '0;
      drive_limit     <= wspf_pkg::DRIVE_LIMIT_RST;
      integral_limit  <= wspf_pkg::INTEGRAL_LIMIT_RST;
      deadzone_offset <= '0;
      ff_slope        <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          wspf_pkg::REG_GAIN_P:          gain_p          <= cfg_data[GW-1:0];
          wspf_pkg::REG_GAIN_I:          gain_i          <= cfg_data[GW-1:0];
          wspf_pkg::REG_GAIN_D:          gain_d          <= cfg_data[GW-1:0];
          wspf_pkg::REG_DRIVE_LIMIT:     drive_limit     <= cfg_data[LW-1:0];
          wspf_pkg::REG_INTEGRAL_LIMIT:  integral_limit  <= cfg_data[LW-1:0];
          wspf_pkg::REG_DEADZONE_OFFSET: deadzone_offset <= cfg_data[GW-1:0];
          wspf_pkg::REG_FF_SLOPE:        ff_slope        <= cfg_data[GW-1:0];
          default: ;
        endcase
      end

      // A new drive word fills the output register; otherwise a claimed
      // word empties it.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_ERR;
          end
        end
        ST_ERR: begin
          // A small target restarts the integral from zero.
          if (!big_now) begin
            integ <= '0;
          end
          state <= ST_IPREP;
        end
        ST_IPREP: begin
          state <= ST_IDIV;
        end
        ST_IDIV: begin
          if (div_done) begin
            state <= ST_IACC;
          end
        end
        ST_IACC: begin
          integ <= integ_new;
          term  <= T_DECAY;
          state <= ST_MLOAD;
        end
        ST_MLOAD: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) begin
            case (term)
              T_DECAY: begin
                term  <= T_DIFF;
                state <= ST_MLOAD;
              end
              T_DIFF: begin
                state <= ST_DPREP;
              end
              T_P: begin
                term  <= T_I;
                state <= ST_MLOAD;
              end
              T_I: begin
                term  <= T_D;
                state <= ST_MLOAD;
              end
              T_D: begin
                if (big_target) begin
                  term  <= T_FF;
                  state <= ST_MLOAD;
                end else begin
                  state <= ST_RND;
                end
              end
              T_FF: begin
                term  <= T_DZ;
                state <= ST_MLOAD;
              end
              default: begin
                state <= ST_RND;
              end
            endcase
          end
        end
        ST_DPREP: begin
          state <= ST_DDIV;
        end
        ST_DDIV: begin
          if (div_done) begin
            state <= ST_DCLAMP;
          end
        end
        ST_DCLAMP: begin
          deriv    <= deriv_new;
          prev_err <= err;
          term     <= T_P;
          state    <= ST_MLOAD;
        end
        ST_RND: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          // Wait here while the previous drive word is still unclaimed.
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Per-word datapath registers.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && s_axis_tvalid) begin
      target   <= s_axis_tdata[FW-1:0];
      measured <= s_axis_tdata[2*FW-1:FW];
    end
    if (state == ST_ERR) begin
      err        <= err_sat;
      big_target <= big_now;
    end
    if ((state == ST_IPREP) || (state == ST_DPREP)) begin
      sign_neg <= rnd_neg;
    end
    if ((state == ST_IACC) || (state == ST_DCLAMP)) begin
      sum <= '0;
    end else if ((state == ST_MUL) && mul_done) begin
      sum <= sum + {{(SW-PW){prod[PW-1]}}, prod};
    end
    if (state == ST_RND) begin
      omag     <= rnd_mag;
      sign_neg <= rnd_neg;
    end
    if (out_load) begin
      out_data <= drive;
    end
  end

endmodule

// File: hdl/wspf_checker.sv
// ----------------------------------------------------------------------------
// wspf_checker
// Port-level checks of the wheel speed controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wspf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [wspf_pkg::FIELD_W-1:0]  m_axis_tdata
);

  // A stalled drive word holds its value.
`WSPF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // One word at a time: the input closes right after an accept.
`WSPF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // No drive word can appear in the cycle right after an accept.
`WSPF_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))

  // Leaving reset, the block is ready and holds no result.
`WSPF_ASSERT_IMPL(a_reset_state, $past(rst), s_axis_tready && !m_axis_tvalid)

endmodule

bind wheel_speed_pid_feedforward_top wspf_checker u_checker (.*);
